// ===== design/tlbpt_pkg.sv =====
// Package for the TLB page table translator.
// Holds the default sizes, the fixed port widths and the control state type.
// No dependencies.
`timescale 1ns / 1ps

package tlbpt_pkg;

    // Default sizes of the translator.
    localparam int DEF_TLB_ENTRIES = 16;
    localparam int DEF_PAGE_COUNT  = 256;
    localparam int DEF_FRAME_COUNT = 256;
    localparam int DEF_OFFSET_BITS = 8;

    // Fixed field widths.
    localparam int VA_W    = 16;
    localparam int PA_W    = 16;
    localparam int COUNT_W = 32;

    // Fixed point scale of the reciprocal that reduces the page number.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 17;

    // Control states of the translator, one-hot.
    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_MUL     = 6'b000100,
        ST_RED     = 6'b001000,
        ST_LOOK    = 6'b010000,
        ST_RESOLVE = 6'b100000
    } state_t;

endpackage

// ===== design/tlbpt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the page table. No dependencies.
`timescale 1ns / 1ps

module tlbpt_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tlbpt_tlb.sv =====
// Fully associative TLB with a registered lookup result and FIFO order fill.
// Stand-alone; sizes come from the parent's parameters.
`timescale 1ns / 1ps

module tlbpt_tlb #(
    parameter int ENTRIES = 16,
    parameter int PAGE_W  = 8,
    parameter int FRAME_W = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               lookup_en,
    input  logic [PAGE_W-1:0]  lookup_page,
    output logic               hit_q,
    output logic [FRAME_W-1:0] frame_q,
    input  logic               fill_en,
    input  logic [PAGE_W-1:0]  fill_page,
    input  logic [FRAME_W-1:0] fill_frame
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [PAGE_W-1:0]  page_reg  [ENTRIES];
    logic [FRAME_W-1:0] frame_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]   ptr_reg;
    logic [IDX_W-1:0]   ptr_next;
    logic               hit_reg;
    logic [FRAME_W-1:0] hit_frame_reg;
    logic               match;
    logic [FRAME_W-1:0] match_frame;

    // Walk from the top down so the lowest-numbered matching entry wins.
    always_comb begin
        match       = 1'b0;
        match_frame = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i] && (page_reg[i] == lookup_page)) begin
                match       = 1'b1;
                match_frame = frame_reg[i];
            end
        end
    end

    always_comb begin
        if (ptr_reg == IDX_W'(ENTRIES - 1)) begin
            ptr_next = '0;
        end else begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            ptr_reg   <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (lookup_en) begin
                hit_reg <= match;
            end
            if (fill_en) begin
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg            <= ptr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (lookup_en) begin
            hit_frame_reg <= match_frame;
        end
        if (fill_en) begin
            page_reg[ptr_reg]  <= fill_page;
            frame_reg[ptr_reg] <= fill_frame;
        end
    end

    assign hit_q   = hit_reg;
    assign frame_q = hit_frame_reg;

endmodule

// ===== design/tlb_page_table_translator_core.sv =====
// Top level of the TLB page table translator.
// Depends on tlbpt_pkg, tlbpt_ram (page table) and tlbpt_tlb (translation cache).
`timescale 1ns / 1ps

// This block translates one 16-bit virtual address per transaction into a
// physical address. The page number is looked up in a fully associative TLB;
// on a miss the page table, held in a synchronous RAM, supplies the frame, and
// a page with no frame yet takes the next frame from a wrapping counter (a page
// fault). Every TLB miss fills the TLB in FIFO order. Each result reports the
// physical address, the hit and fault flags and saturating hit and fault
// totals. After reset the block clears every page table entry and accepts no
// transaction during that pass. An address then passes a lookup state and a
// resolve state, which waits on the registered read of the page table RAM;
// when PAGE_COUNT is not a power of two, a multiply state and a reduce state
// first reduce the page number. A new address is accepted in the resolve cycle
// of the previous one, while the output register keeps a finished result until
// the downstream side takes it; a full output register holds the resolve state.
module tlb_page_table_translator_core #(
    parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES,
    parameter int PAGE_COUNT  = tlbpt_pkg::DEF_PAGE_COUNT,
    parameter int FRAME_COUNT = tlbpt_pkg::DEF_FRAME_COUNT,
    parameter int OFFSET_BITS = tlbpt_pkg::DEF_OFFSET_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input transactions.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] virtual_address
    // Result transactions.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [15:0] phys_addr, [47:16] hit_total,
                                   // [79:48] fault_total
    output logic [1:0]  m_tuser    // [0] tlb_hit, [1] page_fault
);

    localparam int VA_W    = tlbpt_pkg::VA_W;
    localparam int PA_W    = tlbpt_pkg::PA_W;
    localparam int COUNT_W = tlbpt_pkg::COUNT_W;
    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = $clog2(FRAME_COUNT);
    // Width of the page number field of the address; at least one bit.
    localparam int VPN_W   = (VA_W - OFFSET_BITS > 0) ? (VA_W - OFFSET_BITS) : 1;
    localparam bit PAGE_POW2 = ((1 << PAGE_W) == PAGE_COUNT);
    localparam int RECIP_SHIFT = tlbpt_pkg::RECIP_SHIFT;
    localparam int RECIP_W     = tlbpt_pkg::RECIP_W;
    localparam int RECIP       = (1 << RECIP_SHIFT) / PAGE_COUNT;
    localparam int PROD_W      = VPN_W + RECIP_W;
    localparam logic [VA_W-1:0] OFF_MASK = VA_W'((64'd1 << OFFSET_BITS) - 64'd1);

    // Control state.
    tlbpt_pkg::state_t state_reg;
    tlbpt_pkg::state_t state_next;
    logic [PAGE_W-1:0] clr_reg;

    // Item being worked on.
    logic [VA_W-1:0]   va_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [PROD_W-1:0] prod_reg;

    // Architectural counters.
    logic [FRAME_W-1:0] free_frame_reg;
    logic [COUNT_W-1:0] hit_cnt_reg;
    logic [COUNT_W-1:0] fault_cnt_reg;
    logic [COUNT_W-1:0] hit_cnt_next;
    logic [COUNT_W-1:0] fault_cnt_next;

    // Output register.
    logic               m_valid_reg;
    logic [PA_W-1:0]    pa_reg;
    logic               hit_out_reg;
    logic               fault_out_reg;
    logic [COUNT_W-1:0] hit_tot_reg;
    logic [COUNT_W-1:0] fault_tot_reg;

    // Datapath signals.
    logic                s_fire;
    logic                can_finish;
    logic                resolve_fire;
    logic [VPN_W-1:0]    vpn_in;
    logic [VPN_W-1:0]    vpn_cur;
    logic [PAGE_W-1:0]   page_direct;
    logic [VPN_W-1:0]    quot;
    logic [VPN_W-1:0]    rem;
    logic [PAGE_W-1:0]   page_reduced;
    logic                tlb_hit_q;
    logic [FRAME_W-1:0]  tlb_frame_q;
    logic [FRAME_W:0]    tbl_rdata;
    logic                tbl_valid;
    logic [FRAME_W-1:0]  frame;
    logic                fault;
    logic [31:0]         pa_wide;
    logic                ram_we;
    logic [PAGE_W-1:0]   ram_waddr;
    logic [FRAME_W:0]    ram_wdata;
    logic [FRAME_W-1:0]  free_frame_next;

    // A finished result can leave the resolve stage when the output register
    // is empty or is being emptied in the same cycle.
    assign can_finish   = !m_valid_reg || m_tready;
    assign resolve_fire = (state_reg == tlbpt_pkg::ST_RESOLVE) && can_finish;
    assign s_tready     = (state_reg == tlbpt_pkg::ST_IDLE) || resolve_fire;
    assign s_fire       = s_tvalid && s_tready;

    // Page number straight from the address; a mask when PAGE_COUNT is a
    // power of two.
    assign vpn_in      = VPN_W'(s_tdata >> OFFSET_BITS);
    assign page_direct = PAGE_W'(vpn_in);
    assign vpn_cur     = VPN_W'(va_reg >> OFFSET_BITS);

    // Reduction modulo PAGE_COUNT otherwise: the quotient estimate from the
    // reciprocal is low by at most one, so one compare and subtract finishes.
    assign quot = prod_reg[RECIP_SHIFT +: VPN_W];
    assign rem  = vpn_cur - VPN_W'(quot * VPN_W'(PAGE_COUNT));
    always_comb begin
        if (32'(rem) >= PAGE_COUNT) begin
            page_reduced = PAGE_W'(rem - VPN_W'(PAGE_COUNT));
        end else begin
            page_reduced = PAGE_W'(rem);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tlbpt_pkg::ST_CLEAR: begin
                if (clr_reg == PAGE_W'(PAGE_COUNT - 1)) begin
                    state_next = tlbpt_pkg::ST_IDLE;
                end
            end
            tlbpt_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = PAGE_POW2 ? tlbpt_pkg::ST_LOOK : tlbpt_pkg::ST_MUL;
                end
            end
            tlbpt_pkg::ST_MUL: begin
                state_next = tlbpt_pkg::ST_RED;
            end
            tlbpt_pkg::ST_RED: begin
                state_next = tlbpt_pkg::ST_LOOK;
            end
            tlbpt_pkg::ST_LOOK: begin
                state_next = tlbpt_pkg::ST_RESOLVE;
            end
            tlbpt_pkg::ST_RESOLVE: begin
                if (resolve_fire) begin
                    if (s_fire) begin
                        state_next = PAGE_POW2 ? tlbpt_pkg::ST_LOOK : tlbpt_pkg::ST_MUL;
                    end else begin
                        state_next = tlbpt_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = tlbpt_pkg::ST_CLEAR;
            end
        endcase
    end

    // Resolve: a TLB hit wins, then a valid page table entry, and otherwise
    // the page faults and takes the free frame.
    assign tbl_valid = tbl_rdata[FRAME_W];
    assign fault     = !tlb_hit_q && !tbl_valid;
    always_comb begin
        if (tlb_hit_q) begin
            frame = tlb_frame_q;
        end else if (tbl_valid) begin
            frame = tbl_rdata[FRAME_W-1:0];
        end else begin
            frame = free_frame_reg;
        end
    end

    assign pa_wide = (32'(frame) << OFFSET_BITS) | 32'(va_reg & OFF_MASK);

    always_comb begin
        if (free_frame_reg == FRAME_W'(FRAME_COUNT - 1)) begin
            free_frame_next = '0;
        end else begin
            free_frame_next = free_frame_reg + 1'b1;
        end
    end

    assign hit_cnt_next   = (&hit_cnt_reg)   ? hit_cnt_reg   : hit_cnt_reg + 1'b1;
    assign fault_cnt_next = (&fault_cnt_reg) ? fault_cnt_reg : fault_cnt_reg + 1'b1;

    // Page table write port: the clearing pass after reset, then the new
    // mapping of a faulting page. The next address is read no earlier than
    // the cycle after this write, so no forwarding is needed.
    always_comb begin
        if (state_reg == tlbpt_pkg::ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = resolve_fire && fault;
            ram_waddr = page_reg;
            ram_wdata = {1'b1, free_frame_reg};
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tlbpt_pkg::ST_CLEAR;
            clr_reg        <= '0;
            free_frame_reg <= '0;
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == tlbpt_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (resolve_fire) begin
                m_valid_reg <= 1'b1;
                if (tlb_hit_q) begin
                    hit_cnt_reg <= hit_cnt_next;
                end
                if (fault) begin
                    fault_cnt_reg  <= fault_cnt_next;
                    free_frame_reg <= free_frame_next;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            va_reg   <= s_tdata;
            page_reg <= page_direct;
        end
        if (state_reg == tlbpt_pkg::ST_MUL) begin
            prod_reg <= PROD_W'(vpn_cur) * PROD_W'(RECIP);
        end
        if (state_reg == tlbpt_pkg::ST_RED) begin
            page_reg <= page_reduced;
        end
        if (resolve_fire) begin
            pa_reg        <= pa_wide[PA_W-1:0];
            hit_out_reg   <= tlb_hit_q;
            fault_out_reg <= fault;
            hit_tot_reg   <= tlb_hit_q ? hit_cnt_next : hit_cnt_reg;
            fault_tot_reg <= fault ? fault_cnt_next : fault_cnt_reg;
        end
    end

    // Page table: one entry per page, valid bit above the frame number.
    tlbpt_ram #(
        .WIDTH (FRAME_W + 1),
        .DEPTH (PAGE_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (page_reg),
        .rdata (tbl_rdata)
    );

    // TLB: looked up in the lookup cycle, filled on a miss when resolved.
    tlbpt_tlb #(
        .ENTRIES (TLB_ENTRIES),
        .PAGE_W  (PAGE_W),
        .FRAME_W (FRAME_W)
    ) u_tlb (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lookup_en   (state_reg == tlbpt_pkg::ST_LOOK),
        .lookup_page (page_reg),
        .hit_q       (tlb_hit_q),
        .frame_q     (tlb_frame_q),
        .fill_en     (resolve_fire && !tlb_hit_q),
        .fill_page   (page_reg),
        .fill_frame  (frame)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {fault_tot_reg, hit_tot_reg, pa_reg};
    assign m_tuser  = {fault_out_reg, hit_out_reg};

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for tlb_page_table_translator_core.
// Holds its own translator model, a stream driver and a result checker.
// Depends on tlbpt_pkg and the core.
`timescale 1ns / 1ps

module tb;

    localparam int VA_W            = tlbpt_pkg::VA_W;
    localparam int PA_W            = tlbpt_pkg::PA_W;
    localparam int COUNT_W         = tlbpt_pkg::COUNT_W;
    localparam int DEF_TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES;
    localparam int DEF_PAGE_COUNT  = tlbpt_pkg::DEF_PAGE_COUNT;
    localparam int DEF_FRAME_COUNT = tlbpt_pkg::DEF_FRAME_COUNT;
    localparam int DEF_OFFSET_BITS = tlbpt_pkg::DEF_OFFSET_BITS;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int STALL_PERCENT  = 13;

    typedef struct {
        logic [PA_W-1:0]    phys_addr;
        logic               hit;
        logic               fault;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] fault_total;
    } translation_t;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;   // [15:0] phys_addr, [47:16] hit_total,
                             // [79:48] fault_total
    logic [1:0]   m_tuser;   // [0] tlb_hit, [1] page_fault

    // Model state: TLB, page table, FIFO fill slot, free frame and totals.
    int           tlb_tag   [DEF_TLB_ENTRIES];
    int           tlb_frm   [DEF_TLB_ENTRIES];
    bit           tlb_live  [DEF_TLB_ENTRIES];
    int           pt_frm    [DEF_PAGE_COUNT];
    bit           pt_mapped [DEF_PAGE_COUNT];
    int           fill_slot;
    int           next_free;
    bit [COUNT_W-1:0] hit_count;
    bit [COUNT_W-1:0] fault_count;

    translation_t queued_translations[$];
    bit           calm = 1'b0;
    int           errors = 0;
    int           addresses_sent = 0;
    int           translations_checked = 0;
    int           hits_seen = 0;
    int           faults_seen = 0;
    int           quiet_cycles = 0;

    tlb_page_table_translator_core #(
        .TLB_ENTRIES (DEF_TLB_ENTRIES),
        .PAGE_COUNT  (DEF_PAGE_COUNT),
        .FRAME_COUNT (DEF_FRAME_COUNT),
        .OFFSET_BITS (DEF_OFFSET_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Translates one address and advances the model state.
    function automatic translation_t translate_address(input logic [VA_W-1:0] va);
        translation_t res;
        int page;
        int offset;
        int frame;
        int slot;
        int pa_full;
        bit found;
        found  = 1'b0;
        frame  = 0;
        offset = va & ((1 << DEF_OFFSET_BITS) - 1);
        page   = (va >> DEF_OFFSET_BITS) % DEF_PAGE_COUNT;
        res.fault = 1'b0;
        // The lowest-numbered valid match wins.
        for (int i = 0; i < DEF_TLB_ENTRIES; i++) begin
            if (!found && tlb_live[i] && tlb_tag[i] == page) begin
                found = 1'b1;
                frame = tlb_frm[i];
            end
        end
        if (found) begin
            if (hit_count != '1) hit_count++;
        end else begin
            if (pt_mapped[page]) begin
                frame = pt_frm[page];
            end else begin
                frame = next_free;
                next_free = (next_free + 1) % DEF_FRAME_COUNT;
                pt_frm[page] = frame;
                pt_mapped[page] = 1'b1;
                res.fault = 1'b1;
                if (fault_count != '1) fault_count++;
            end
            slot = fill_slot;
            tlb_tag[slot]  = page;
            tlb_frm[slot]  = frame;
            tlb_live[slot] = 1'b1;
            fill_slot = (slot + 1) % DEF_TLB_ENTRIES;
        end
        pa_full = (frame << DEF_OFFSET_BITS) | offset;
        res.phys_addr   = pa_full[PA_W-1:0];
        res.hit         = found;
        res.hit_total   = hit_count;
        res.fault_total = fault_count;
        return res;
    endfunction

    function automatic logic [VA_W-1:0] compose_va(input int page, input int offset);
        int full;
        full = (page << DEF_OFFSET_BITS) | (offset & ((1 << DEF_OFFSET_BITS) - 1));
        return full[VA_W-1:0];
    endfunction

    // Offers one address, waits for the handshake and records its translation.
    task automatic send_address(input logic [VA_W-1:0] va);
        int gap;
        if (!calm && $urandom_range(0, 99) < STALL_PERCENT) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= va;
        do @(posedge aclk); while (!s_tready);
        queued_translations.push_back(translate_address(va));
        addresses_sent++;
    endtask

    // Holds the input side off until every outstanding translation is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (queued_translations.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        translation_t want;
        if (queued_translations.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%b",
                     $time, m_tdata, m_tuser);
            errors++;
            return;
        end
        want = queued_translations.pop_front();
        translations_checked++;
        hits_seen   += m_tuser[0];
        faults_seen += m_tuser[1];
        compare_field("phys_addr", want.phys_addr, m_tdata[15:0]);
        compare_field("tlb_hit", want.hit, m_tuser[0]);
        compare_field("page_fault", want.fault, m_tuser[1]);
        compare_field("hit_total", want.hit_total, m_tdata[47:16]);
        compare_field("fault_total", want.fault_total, m_tdata[79:48]);
    endtask

    // Result side: check each accepted transaction, stall at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result();
            m_tready <= calm || ($urandom_range(0, 99) >= STALL_PERCENT);
        end
    end

    // Ends the run when no transaction moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d translations outstanding",
                         $time, queued_translations.size());
                $display("tlb_page_table_translator_core regression: fail");
                $finish;
            end
        end
    end

    // Address extremes on an empty TLB: faults, then hits on the same pages.
    task automatic test_extremes();
        send_address(16'h0000);
        send_address(16'h00FF);
        send_address(16'hFFFF);
        send_address(16'hFF00);
    endtask

    // Overfills the TLB so that FIFO replacement evicts early pages, which
    // then miss in the TLB but are found in the page table.
    task automatic test_fifo_eviction();
        for (int p = 1; p < DEF_TLB_ENTRIES; p++) begin
            send_address(compose_va(p, $urandom_range(0, 255)));
        end
        send_address(16'h0012);
        send_address(16'hFF34);
        send_address(16'h0FAA);
    endtask

    // Bursts over small working sets reach hits and capacity misses; single
    // random addresses act as noise.
    task automatic test_working_sets(input int count);
        int base;
        int span;
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 70) begin
                base  = $urandom_range(0, DEF_PAGE_COUNT - 1);
                span  = $urandom_range(1, 20);
                burst = $urandom_range(10, 50);
                for (int k = 0; k < burst && sent < count; k++) begin
                    send_address(compose_va((base + $urandom_range(0, span - 1))
                                            % DEF_PAGE_COUNT, $urandom));
                    sent++;
                end
            end else begin
                burst = $urandom_range(1, 8);
                for (int k = 0; k < burst && sent < count; k++) begin
                    send_address(VA_W'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // Touches every page in random order, so every page gets a frame and the
    // free frame counter wraps; runs without any idling.
    task automatic test_frame_wrap();
        int order[DEF_PAGE_COUNT];
        int j;
        int t;
        for (int i = 0; i < DEF_PAGE_COUNT; i++) order[i] = i;
        for (int i = DEF_PAGE_COUNT - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        calm = 1'b1;
        for (int i = 0; i < DEF_PAGE_COUNT; i++) begin
            send_address(compose_va(order[i], $urandom));
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_fifo_eviction();
        test_working_sets(420);
        drain_results();
        test_frame_wrap();
        test_working_sets(420);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d addresses, checked %0d translations (%0d TLB hits, %0d page faults).",
                 addresses_sent, translations_checked, hits_seen, faults_seen);
        $display("Covered address extremes, FIFO eviction, working sets and free frame wrap.");
        if (errors == 0 && queued_translations.size() == 0) begin
            $display("tlb_page_table_translator_core regression: pass");
        end else begin
            $display("tlb_page_table_translator_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tlbpt_pkg.sv
design/tlbpt_ram.sv
design/tlbpt_tlb.sv
design/tlb_page_table_translator_core.sv
tb/tb.sv
